// ===== rtl/core/hsra_pkg.sv =====
// Shared constants, types and arctangent table of the Hall sensor rotor angle block.
`default_nettype none

package hsra_pkg;

   localparam int SAMPLE_BITS   = 12;
   localparam int ANGLE_BITS    = 16;
   localparam int CORDIC_STAGES = 16;
   localparam int GUARD_BITS    = 24;
   localparam int ATAN_ENTRIES  = 24;
   localparam int NUM_STAGES    = (CORDIC_STAGES < ATAN_ENTRIES) ? CORDIC_STAGES : ATAN_ENTRIES;

   localparam int DIFF_W = SAMPLE_BITS + 1;
   localparam int VEC_W  = DIFF_W + GUARD_BITS + 3;
   localparam int ACC_W  = 32;

   typedef logic        [SAMPLE_BITS-1:0] sample_type;
   typedef logic signed [DIFF_W-1:0]      diff_type;
   typedef logic signed [VEC_W-1:0]       vec_type;
   typedef logic        [ACC_W-1:0]       acc_type;
   typedef logic signed [ANGLE_BITS-1:0]  angle_type;

   typedef struct packed {
      vec_type x;
      vec_type y;
      acc_type z;
      logic    zero;
   } cord_type;

   localparam acc_type Z_QUARTER_POS = 32'h4000_0000;
   localparam acc_type Z_QUARTER_NEG = 32'hC000_0000;
   localparam acc_type ROUND_ONE     = acc_type'(1) << (ACC_W - 1 - ANGLE_BITS);

   localparam acc_type ATAN_TABLE [ATAN_ENTRIES] = '{
      32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
      32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
      32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
      32'd166886,    32'd83443,     32'd41722,     32'd20861,
      32'd10430,     32'd5215,      32'd2608,      32'd1304,
      32'd652,       32'd326,       32'd163,       32'd81
   };

endpackage

`default_nettype wire

// ===== rtl/core/hall_sensor_rotor_angle.sv =====
// Rotor angle from four Hall sensor samples, pipelined vectoring CORDIC.
//
// Input channel req_*: one transfer carries four 12-bit unsigned samples from
// sensors placed 90 degrees apart. X = A - C and Y = B - D.
// Result channel rsp_*: one transfer per input, rsp_rotor_angle = atan2(Y, X)
// as a signed 16-bit binary angle where 32768 stands for pi. A zero vector
// gives 0. Results leave in input order.
// Pipeline: one pre-rotation stage, 16 CORDIC stages, one rounding/output
// stage. Throughput: one transfer per cycle while rsp_ready stays high; each
// stage holds one item and the ready of a stage is set by whether it is
// empty or its successor moves.
// When rsp_ready is low, the output stage holds its result and the stages
// behind it keep filling until full, then req_ready drops; nothing is lost.
// Reset (synchronous, active high) empties every stage; the block keeps no
// other state.
`default_nettype none

module hall_sensor_rotor_angle
   import hsra_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire sample_type req_hall_a,
   input  wire sample_type req_hall_b,
   input  wire sample_type req_hall_c,
   input  wire sample_type req_hall_d,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output angle_type       rsp_rotor_angle
);

   logic     pre_valid;
   logic     pre_ready;
   cord_type pre_data;
   logic     cor_valid;
   logic     cor_ready;
   cord_type cor_data;

   hsra_prerot u_prerot (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .hall_a    (req_hall_a),
      .hall_b    (req_hall_b),
      .hall_c    (req_hall_c),
      .hall_d    (req_hall_d),
      .out_valid (pre_valid),
      .out_ready (pre_ready),
      .out_data  (pre_data)
   );

   hsra_cordic u_cordic (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (pre_valid),
      .in_ready  (pre_ready),
      .in_data   (pre_data),
      .out_valid (cor_valid),
      .out_ready (cor_ready),
      .out_data  (cor_data)
   );

   hsra_round u_round (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (cor_valid),
      .in_ready  (cor_ready),
      .in_data   (cor_data),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_angle (rsp_rotor_angle)
   );

endmodule

`default_nettype wire

// ===== rtl/core/hsra_prerot.sv =====
// Input stage: axis differences, zero detection and quarter-turn pre-rotation.
`default_nettype none

module hsra_prerot
   import hsra_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       in_valid,
   output logic            in_ready,
   input  wire sample_type hall_a,
   input  wire sample_type hall_b,
   input  wire sample_type hall_c,
   input  wire sample_type hall_d,
   output logic            out_valid,
   input  wire logic       out_ready,
   output cord_type        out_data
);

   diff_type dx;
   diff_type dy;
   diff_type px;
   diff_type py;
   acc_type  pz;
   cord_type data_in;
   cord_type data_ff;
   logic     valid_ff;

   assign dx = $signed({1'b0, hall_a} - {1'b0, hall_c});
   assign dy = $signed({1'b0, hall_b} - {1'b0, hall_d});

   always_comb begin
      px = dx;
      py = dy;
      pz = '0;
      if (dx[DIFF_W-1]) begin
         if (!dy[DIFF_W-1]) begin
            px = dy;
            py = -dx;
            pz = Z_QUARTER_POS;
         end else begin
            px = -dy;
            py = dx;
            pz = Z_QUARTER_NEG;
         end
      end
   end

   always_comb begin
      data_in.x    = vec_type'(px) <<< GUARD_BITS;
      data_in.y    = vec_type'(py) <<< GUARD_BITS;
      data_in.z    = pz;
      data_in.zero = (dx == '0) && (dy == '0);
   end

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

`default_nettype wire

// ===== rtl/core/hsra_cordic.sv =====
// Vectoring CORDIC pipeline: one registered micro-rotation per stage.
`default_nettype none

module hsra_cordic
   import hsra_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     in_valid,
   output logic          in_ready,
   input  wire cord_type in_data,
   output logic          out_valid,
   input  wire logic     out_ready,
   output cord_type      out_data
);

   cord_type stage_ff    [NUM_STAGES];
   cord_type stage_in    [NUM_STAGES];
   logic     valid_ff    [NUM_STAGES];
   logic     stage_ready [NUM_STAGES];

   for (genvar g = 0; g < NUM_STAGES; g++) begin : gen_stage
      cord_type src;
      logic     src_valid;
      logic     dst_ready;
      vec_type  xs;
      vec_type  ys;

      if (g == 0) begin : gen_first
         assign src       = in_data;
         assign src_valid = in_valid;
      end else begin : gen_next
         assign src       = stage_ff[g-1];
         assign src_valid = valid_ff[g-1];
      end

      if (g == NUM_STAGES - 1) begin : gen_last
         assign dst_ready = out_ready;
      end else begin : gen_mid
         assign dst_ready = stage_ready[g+1];
      end

      assign stage_ready[g] = !valid_ff[g] || dst_ready;
      assign xs = src.x >>> g;
      assign ys = src.y >>> g;

      always_comb begin
         stage_in[g].zero = src.zero;
         if (!src.y[VEC_W-1]) begin
            stage_in[g].x = src.x + ys;
            stage_in[g].y = src.y - xs;
            stage_in[g].z = src.z + ATAN_TABLE[g];
         end else begin
            stage_in[g].x = src.x - ys;
            stage_in[g].y = src.y + xs;
            stage_in[g].z = src.z - ATAN_TABLE[g];
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[g] <= 1'b0;
         end else if (stage_ready[g]) begin
            valid_ff[g] <= src_valid;
         end
      end

      always_ff @(posedge clock) begin
         if (stage_ready[g] && src_valid) begin
            stage_ff[g] <= stage_in[g];
         end
      end
   end

   assign in_ready  = stage_ready[0];
   assign out_valid = valid_ff[NUM_STAGES-1];
   assign out_data  = stage_ff[NUM_STAGES-1];

endmodule

`default_nettype wire

// ===== rtl/core/hsra_round.sv =====
// Output stage: round the turn accumulator to the angle width and hold the result.
`default_nettype none

module hsra_round
   import hsra_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     in_valid,
   output logic          in_ready,
   input  wire cord_type in_data,
   output logic          out_valid,
   input  wire logic     out_ready,
   output angle_type     out_angle
);

   acc_type   rounded;
   angle_type angle_in;
   angle_type angle_ff;
   logic      valid_ff;

   assign rounded  = in_data.z + ROUND_ONE;
   assign angle_in = in_data.zero ? '0 : angle_type'(rounded[ACC_W-1 -: ANGLE_BITS]);
   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         angle_ff <= angle_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_angle = angle_ff;

endmodule

`default_nettype wire
